// ----- src/ple_pkg.sv -----
// ple_pkg: request codes and status codes of the positional list engine
// no dependencies; used by positional_list_engine_unit
package ple_pkg;

  // request codes
  localparam logic [3:0] FN_INS_FIRST = 4'd0;
  localparam logic [3:0] FN_INS_LAST  = 4'd1;
  localparam logic [3:0] FN_INS_AT    = 4'd2;
  localparam logic [3:0] FN_DEL_FIRST = 4'd3;
  localparam logic [3:0] FN_DEL_LAST  = 4'd4;
  localparam logic [3:0] FN_DEL_AT    = 4'd5;
  localparam logic [3:0] FN_FIND_FST  = 4'd6;
  localparam logic [3:0] FN_FIND_LST  = 4'd7;
  localparam logic [3:0] FN_CLEAR     = 4'd8;

  // result status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

// ----- src/positional_list_engine_unit.sv -----
// positional_list_engine_unit: ordered list of up to DEPTH words held in one
// synchronous slot memory, with a sequencer that shifts, scans and summarizes
// depends on ple_pkg
//
//  channel | direction | ports
//  --------+-----------+-------------------------------------------------
//  in      | to block  | in_valid, in_ready, in_func, in_value, in_position
//  out     | from block| out_valid, out_ready, out_status, out_found,
//          |           | out_found_position, out_entry_count, out_head_value,
//          |           | out_tail_value, out_is_empty
//
// steps: one slot memory with a registered read; each moved entry is read,
//   then written, and each scanned entry is read, then compared (find first
//   stops at its first match); every request ends by reading the head and
//   the tail entry, and the block returns to idle before it takes the next.
// reset: clears the entry count and the control; slots need no clearing.
// stalls: a finished result waits in the output register while the next
//   request is already taken; the block holds only at its final step when the
//   previous result has not been transferred.
module positional_list_engine_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_func,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [6:0]  out_found_position,
  output logic [6:0]  out_entry_count,
  output logic [31:0] out_head_value,
  output logic [31:0] out_tail_value,
  output logic        out_is_empty
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = ((CNT_W > 7) ? CNT_W : 7) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_MV, S_DEL_MV, S_WR, S_PUT, S_SC_RD, S_SC_CMP,
    S_HEAD, S_TAIL, S_FIN
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        occ_r;
  logic [CNT_W-1:0]        cur_r;
  logic [CNT_W-1:0]        tgt_r;
  logic                    is_ins_r;
  logic                    find_first_r;
  logic [DATA_WIDTH-1:0]   val_r;
  logic [DATA_WIDTH-1:0]   head_r;
  ple_pkg::status_t        status_r;
  logic                    found_r;
  logic [CNT_W-1:0]        fpos_r;
  logic                    out_valid_r;

  // slot memory
  logic [DATA_WIDTH-1:0]   slots [DEPTH];
  logic [DATA_WIDTH-1:0]   rdata_r;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [DATA_WIDTH-1:0]   wr_data;

  // request decode at the input
  logic [DATA_WIDTH-1:0]   in_val;
  logic [PW-1:0]           pos_w;
  logic [PW-1:0]           occ_w;
  logic                    full;
  logic                    fin_go;

  assign in_val   = DATA_WIDTH'(in_value);
  assign pos_w    = PW'(in_position);
  assign occ_w    = PW'(occ_r);
  assign full     = (occ_r == CNT_W'(DEPTH));
  assign in_ready = (state_r == S_IDLE);
  assign fin_go   = !out_valid_r || out_ready;

  // memory port control; reads and writes of one entry never share a cycle,
  // the sequencer orders them
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = AW'(cur_r);
    wr_data = rdata_r;
    case (state_r)
      S_INS_MV: begin
        rd_en   = (cur_r > tgt_r);
        rd_addr = AW'(cur_r - 1'b1);
      end
      S_DEL_MV: begin
        rd_en   = ((cur_r + 1'b1) < occ_r);
        rd_addr = AW'(cur_r + 1'b1);
      end
      S_WR: wr_en = 1'b1;
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(tgt_r);
        wr_data = val_r;
      end
      S_SC_RD: begin
        rd_en   = (cur_r < occ_r);
        rd_addr = AW'(cur_r);
      end
      S_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_TAIL: begin
        rd_en   = 1'b1;
        rd_addr = AW'(occ_r - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= slots[rd_addr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            val_r        <= in_val;
            found_r      <= 1'b0;
            fpos_r       <= '0;
            find_first_r <= (in_func == ple_pkg::FN_FIND_FST);
            case (in_func)
              ple_pkg::FN_INS_FIRST, ple_pkg::FN_INS_LAST, ple_pkg::FN_INS_AT: begin
                is_ins_r <= 1'b1;
                cur_r    <= occ_r;
                if (in_func == ple_pkg::FN_INS_FIRST) tgt_r <= '0;
                else if (in_func == ple_pkg::FN_INS_LAST) tgt_r <= occ_r;
                else tgt_r <= CNT_W'(pos_w - 1'b1);
                if (full) begin
                  status_r <= ple_pkg::ST_FULL;
                  state_r  <= S_HEAD;
                end else if (in_func == ple_pkg::FN_INS_AT &&
                             (pos_w == '0 || pos_w > occ_w + 1'b1)) begin
                  status_r <= ple_pkg::ST_BADPOS;
                  state_r  <= S_HEAD;
                end else begin
                  status_r <= ple_pkg::ST_OK;
                  state_r  <= S_INS_MV;
                end
              end
              ple_pkg::FN_DEL_FIRST, ple_pkg::FN_DEL_LAST: begin
                is_ins_r <= 1'b0;
                cur_r    <= (in_func == ple_pkg::FN_DEL_FIRST) ? '0 : occ_r - 1'b1;
                if (occ_r == '0) begin
                  status_r <= ple_pkg::ST_EMPTY;
                  state_r  <= S_HEAD;
                end else begin
                  status_r <= ple_pkg::ST_OK;
                  state_r  <= S_DEL_MV;
                end
              end
              ple_pkg::FN_DEL_AT: begin
                is_ins_r <= 1'b0;
                cur_r    <= CNT_W'(pos_w - 1'b1);
                if (pos_w == '0 || pos_w > occ_w) begin
                  status_r <= ple_pkg::ST_BADPOS;
                  state_r  <= S_HEAD;
                end else begin
                  status_r <= ple_pkg::ST_OK;
                  state_r  <= S_DEL_MV;
                end
              end
              ple_pkg::FN_FIND_FST, ple_pkg::FN_FIND_LST: begin
                cur_r    <= '0;
                status_r <= ple_pkg::ST_OK;
                state_r  <= S_SC_RD;
              end
              ple_pkg::FN_CLEAR: begin
                occ_r    <= '0;
                status_r <= ple_pkg::ST_OK;
                state_r  <= S_HEAD;
              end
              default: begin
                status_r <= ple_pkg::ST_OK;
                state_r  <= S_HEAD;
              end
            endcase
          end
        end
        // open a gap: move entries up one place, top first
        S_INS_MV: state_r <= (cur_r > tgt_r) ? S_WR : S_PUT;
        // close the gap: move entries down one place, bottom first
        S_DEL_MV: begin
          if ((cur_r + 1'b1) < occ_r) state_r <= S_WR;
          else begin
            occ_r   <= occ_r - 1'b1;
            state_r <= S_HEAD;
          end
        end
        S_WR: begin
          if (is_ins_r) begin
            cur_r   <= cur_r - 1'b1;
            state_r <= S_INS_MV;
          end else begin
            cur_r   <= cur_r + 1'b1;
            state_r <= S_DEL_MV;
          end
        end
        S_PUT: begin
          occ_r   <= occ_r + 1'b1;
          state_r <= S_HEAD;
        end
        // search scan, one entry per read/compare pair
        S_SC_RD: state_r <= (cur_r < occ_r) ? S_SC_CMP : S_HEAD;
        S_SC_CMP: begin
          cur_r <= cur_r + 1'b1;
          if (rdata_r == val_r) begin
            found_r <= 1'b1;
            fpos_r  <= cur_r + 1'b1;
            state_r <= find_first_r ? S_HEAD : S_SC_RD;
          end else begin
            state_r <= S_SC_RD;
          end
        end
        // list summary: first and last entry
        S_HEAD: state_r <= S_TAIL;
        S_TAIL: begin
          head_r  <= rdata_r;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r        <= 1'b1;
            out_status         <= status_r;
            out_found          <= found_r;
            out_found_position <= 7'(fpos_r);
            out_entry_count    <= 7'(occ_r);
            out_is_empty       <= (occ_r == '0);
            out_head_value     <= (occ_r == '0) ? '0 : 32'(head_r);
            out_tail_value     <= (occ_r == '0) ? '0 : 32'(rdata_r);
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH)) else $error("entry count above depth");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE)) else $error("request dropped");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && fin_go && status_r == ple_pkg::ST_FULL) |-> full)
    else $error("full status on a list that is not full");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && found_r) |-> (status_r == ple_pkg::ST_OK && fpos_r != '0))
    else $error("match reported with bad status or position");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !fin_go) |=> (state_r == S_FIN))
    else $error("result lost while output held");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for positional_list_engine_unit
// depends on ple_pkg and the block; keeps its own list model and checks every result
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic [3:0] FN_UNUSED_LO = 4'd9;
  localparam logic [3:0] FN_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [6:0]  fpos;
    logic [6:0]  count;
    logic [31:0] head;
    logic [31:0] tail;
    logic        empty;
  } list_summary_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_func = '0;
  logic [31:0] in_value = '0;
  logic [6:0]  in_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_found;
  logic [6:0]  out_found_position;
  logic [6:0]  out_entry_count;
  logic [31:0] out_head_value;
  logic [31:0] out_tail_value;
  logic        out_is_empty;

  positional_list_engine_unit #(.DEPTH(DEPTH), .DATA_WIDTH(32)) u_dut (.*);

  always #1 clk = ~clk;

  // shadow list and pending expectations
  logic [31:0]   shadow_list[DEPTH];
  int            shadow_count;
  list_summary_t pending_summaries[$];
  int            errors;
  int            sent_items;
  int            checked_items;
  bit            idle_enable;
  int            func_hits[16];

  // list behavior model: apply one request, return the summary
  function automatic list_summary_t apply_request(logic [3:0] fn, logic [31:0] v,
                                                  logic [6:0] p);
    list_summary_t r;
    int idx;
    int i;
    r = '0;
    idx = -1;
    r.status = ple_pkg::ST_OK;
    case (fn)
      ple_pkg::FN_INS_FIRST, ple_pkg::FN_INS_LAST, ple_pkg::FN_INS_AT: begin
        if (shadow_count >= DEPTH) r.status = ple_pkg::ST_FULL;
        else if (fn == ple_pkg::FN_INS_FIRST) idx = 0;
        else if (fn == ple_pkg::FN_INS_LAST) idx = shadow_count;
        else if (p < 1 || p > shadow_count + 1) r.status = ple_pkg::ST_BADPOS;
        else idx = p - 1;
        if (idx >= 0) begin
          for (i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = v;
          shadow_count++;
        end
      end
      ple_pkg::FN_DEL_FIRST, ple_pkg::FN_DEL_LAST, ple_pkg::FN_DEL_AT: begin
        if (fn != ple_pkg::FN_DEL_AT && shadow_count == 0) r.status = ple_pkg::ST_EMPTY;
        else if (fn == ple_pkg::FN_DEL_FIRST) idx = 0;
        else if (fn == ple_pkg::FN_DEL_LAST) idx = shadow_count - 1;
        else if (p < 1 || p > shadow_count) r.status = ple_pkg::ST_BADPOS;
        else idx = p - 1;
        if (idx >= 0) begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      ple_pkg::FN_FIND_FST, ple_pkg::FN_FIND_LST: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == v && !(fn == ple_pkg::FN_FIND_FST && r.found)) begin
            r.found = 1'b1;
            r.fpos = 7'(i + 1);
          end
        end
      end
      ple_pkg::FN_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.count = 7'(shadow_count);
    r.empty = (shadow_count == 0);
    if (shadow_count > 0) begin
      r.head = shadow_list[0];
      r.tail = shadow_list[shadow_count-1];
    end
    return r;
  endfunction

  // send one request, wait for its transfer; valid stays high into the next
  // request unless an idle gap is inserted
  task automatic send_request(logic [3:0] fn, logic [31:0] v, logic [6:0] p);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_value <= v;
    in_position <= p;
    @(posedge clk iff in_ready);
    pending_summaries.push_back(apply_request(fn, v, p));
    func_hits[fn]++;
    sent_items++;
  endtask

  // receiver back-pressure in bursts
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    list_summary_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_summaries.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_summaries.pop_front();
        checked_items++;
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_found); errors++;
        end
        if (out_found_position !== e.fpos) begin
          $error("found_position exp %0d got %0d", e.fpos, out_found_position); errors++;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, out_entry_count); errors++;
        end
        if (out_head_value !== e.head) begin
          $error("head_value exp %h got %h", e.head, out_head_value); errors++;
        end
        if (out_tail_value !== e.tail) begin
          $error("tail_value exp %h got %h", e.tail, out_tail_value); errors++;
        end
        if (out_is_empty !== e.empty) begin
          $error("is_empty exp %0d got %0d", e.empty, out_is_empty); errors++;
        end
      end
    end
  end

  // stop sending and wait for every expected result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
  endtask

  // directed: extremes, every request, empty and bad position cases
  task automatic test_directed();
    send_request(ple_pkg::FN_DEL_FIRST, '0, '0);
    send_request(ple_pkg::FN_DEL_LAST, '0, '0);
    send_request(ple_pkg::FN_DEL_AT, '0, 7'd1);
    send_request(ple_pkg::FN_FIND_FST, 32'h0, '0);
    send_request(ple_pkg::FN_INS_AT, 32'hFFFF_FFFF, 7'd0);
    send_request(ple_pkg::FN_INS_AT, 32'hFFFF_FFFF, 7'd2);
    send_request(ple_pkg::FN_INS_AT, 32'hFFFF_FFFF, 7'd1);
    send_request(ple_pkg::FN_INS_FIRST, 32'h0, '0);
    send_request(ple_pkg::FN_INS_LAST, 32'hA5A5_5A5A, '0);
    send_request(ple_pkg::FN_INS_AT, 32'hFFFF_FFFF, 7'd4);
    send_request(ple_pkg::FN_FIND_FST, 32'hFFFF_FFFF, '0);
    send_request(ple_pkg::FN_FIND_LST, 32'hFFFF_FFFF, '0);
    send_request(ple_pkg::FN_FIND_LST, 32'h1234_5678, '0);
    send_request(ple_pkg::FN_DEL_AT, '0, 7'd0);
    send_request(ple_pkg::FN_DEL_AT, '0, 7'd127);
    send_request(ple_pkg::FN_DEL_AT, '0, 7'd2);
    send_request(ple_pkg::FN_DEL_FIRST, '0, '0);
    send_request(ple_pkg::FN_DEL_LAST, '0, '0);
    send_request(FN_UNUSED_LO, 32'h5555_AAAA, 7'h55);
    send_request(FN_UNUSED_HI, 32'hAAAA_5555, 7'h2A);
    send_request(ple_pkg::FN_CLEAR, '0, '0);
  endtask

  // fill to the limit, hit full on each insert request kind, then delete, reinsert, find and clear
  task automatic test_full_list();
    int i;
    for (i = 0; i < DEPTH; i++) send_request(ple_pkg::FN_INS_LAST, $urandom, '0);
    send_request(ple_pkg::FN_INS_FIRST, $urandom, '0);
    send_request(ple_pkg::FN_INS_LAST, $urandom, '0);
    send_request(ple_pkg::FN_INS_AT, $urandom, 7'd0);
    send_request(ple_pkg::FN_DEL_AT, '0, 7'd64);
    send_request(ple_pkg::FN_INS_AT, 32'hDEAD_BEEF, 7'd64);
    send_request(ple_pkg::FN_FIND_LST, 32'hDEAD_BEEF, '0);
    send_request(ple_pkg::FN_DEL_AT, '0, 7'd65);
    send_request(ple_pkg::FN_CLEAR, '0, '0);
  endtask

  // random mix with a small value pool so finds hit
  task automatic test_random(int n);
    int i;
    logic [3:0]  fn;
    logic [31:0] v;
    logic [6:0]  p;
    for (i = 0; i < n; i++) begin
      if (i == n / 2) begin
        wait_drained();
      end
      if (i == n - n / 5) idle_enable = 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: fn = ple_pkg::FN_INS_FIRST;
        4, 5, 6:    fn = ple_pkg::FN_INS_LAST;
        7, 8, 9:    fn = ple_pkg::FN_INS_AT;
        10:         fn = ple_pkg::FN_DEL_FIRST;
        11:         fn = ple_pkg::FN_DEL_LAST;
        12, 13:     fn = ple_pkg::FN_DEL_AT;
        14, 15:     fn = ple_pkg::FN_FIND_FST;
        16, 17:     fn = ple_pkg::FN_FIND_LST;
        18:         fn = ($urandom_range(0, 3) == 0) ? ple_pkg::FN_CLEAR :
                         4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        default:    fn = 4'($urandom_range(0, 15));
      endcase
      v = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
      p = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, shadow_count + 1));
      send_request(fn, v, p);
    end
  endtask

  initial begin
    int codes_seen;
    errors = 0;
    sent_items = 0;
    checked_items = 0;
    shadow_count = 0;
    codes_seen = 0;
    idle_enable = 1'b1;
    foreach (func_hits[k]) func_hits[k] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_random(600);
    wait_drained();
    repeat (300) @(posedge clk);
    foreach (func_hits[k]) if (func_hits[k] != 0) codes_seen++;
    $display("covered %0d requests over %0d request codes, %0d results checked",
             sent_items, codes_seen, checked_items);
    $display("full, empty and bad position cases exercised with random back-pressure");
    if (errors == 0 && pending_summaries.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // overall run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
src/ple_pkg.sv
src/positional_list_engine_unit.sv
dv/tb_top.sv
